// ===== rtl/wkm_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the weighted k-means pass core
// no dependencies
package wkm_pkg;

  localparam int unsigned VAL_W  = 48;
  localparam int unsigned WGT_W  = 32;
  localparam int unsigned PW_W   = 16;
  localparam int unsigned COST_W = 64;
  localparam int unsigned IDX_W  = 6;

  typedef enum logic [1:0] {
    CMD_LOAD_SUM = 2'd0,
    CMD_LOAD_WGT = 2'd1,
    CMD_POINT    = 2'd2,
    CMD_FINISH   = 2'd3
  } cmd_e;

  typedef enum logic {
    RES_POINT = 1'b0,
    RES_TOTAL = 1'b1
  } res_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SCAN,
    ST_DRAIN,
    ST_COST,
    ST_CADD,
    ST_MRD,
    ST_MWR,
    ST_MWGT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             last_l;
    logic [IDX_W-1:0] ctr;
  } tag_t;

  typedef struct packed {
    logic             vld;
    logic [WGT_W-1:0] rem;
    logic [VAL_W-1:0] quo;
    logic [WGT_W-1:0] dvs;
    logic             neg;
    tag_t             tag;
  } div_beat_t;

endpackage

// ===== rtl/wkm_div_cell.sv =====
`timescale 1ns / 1ps
// one restoring division cell: produces one quotient bit and passes on
// depends on wkm_pkg
module wkm_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wkm_pkg::div_beat_t in_i,
  output wkm_pkg::div_beat_t out_o
);
  import wkm_pkg::*;

  logic [WGT_W:0]   trial;
  logic             ge;
  logic [WGT_W:0]   diff;
  logic             vld_q;
  div_beat_t        pay_q;

  assign trial = {in_i.rem, in_i.quo[VAL_W-1]};
  assign ge    = trial >= {1'b0, in_i.dvs};
  assign diff  = trial - {1'b0, in_i.dvs};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= in_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q.vld <= 1'b0;
    pay_q.rem <= ge ? diff[WGT_W-1:0] : trial[WGT_W-1:0];
    pay_q.quo <= {in_i.quo[VAL_W-2:0], ge};
    pay_q.dvs <= in_i.dvs;
    pay_q.neg <= in_i.neg;
    pay_q.tag <= in_i.tag;
  end

  always_comb begin
    out_o     = pay_q;
    out_o.vld = vld_q;
  end

endmodule

// ===== rtl/wkm_div_chain.sv =====
`timescale 1ns / 1ps
// row of division cells: signed 48-bit by unsigned 32-bit, truncating,
// a zero divisor passes the dividend through; depends on wkm_pkg, wkm_div_cell
module wkm_div_chain (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               vld_i,
  input  logic signed [wkm_pkg::VAL_W-1:0]   dividend_i,
  input  logic        [wkm_pkg::WGT_W-1:0]   divisor_i,
  input  wkm_pkg::tag_t                      tag_i,
  output logic                               vld_o,
  output logic signed [wkm_pkg::VAL_W-1:0]   quot_o,
  output wkm_pkg::tag_t                      tag_o
);
  import wkm_pkg::*;

  div_beat_t link [VAL_W+1];

  always_comb begin
    link[0].vld = vld_i;
    link[0].rem = '0;
    link[0].neg = dividend_i[VAL_W-1];
    link[0].quo = dividend_i[VAL_W-1] ? (~dividend_i + 1'b1) : dividend_i;
    // dividing by one reproduces the raw value
    link[0].dvs = (divisor_i == '0) ? WGT_W'(1) : divisor_i;
    link[0].tag = tag_i;
  end

  for (genvar g = 0; g < VAL_W; g++) begin : g_cell
    wkm_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .in_i   (link[g]),
      .out_o  (link[g+1])
    );
  end

  assign vld_o  = link[VAL_W].vld;
  assign quot_o = link[VAL_W].neg ? (~link[VAL_W].quo + 1'b1) : link[VAL_W].quo;
  assign tag_o  = link[VAL_W].tag;

endmodule

// ===== rtl/weighted_kmeans_lloyd_pass_core.sv =====
`timescale 1ns / 1ps
// weighted k-means lloyd pass: centre and mass stores, scan control, distance
// depends on wkm_pkg, wkm_div_chain
//
// slave channel: tuser = command, tlast = last dimension of a point, tdata holds
// centre index, dimension index, value and point weight. master channel: tuser =
// result kind, tdata = nearest centre and cost. one result beat per point and
// per finish command; load beats and non-last point beats return nothing.
// a last point beat scans all CENTRES*DIMS centre coordinates through two
// 48-cell divider rows, one coordinate a cycle, then updates the mass of the
// nearest centre when the point weight is nonzero. a finish beat sweeps the
// stores, copying masses into the centres and clearing them. after reset the
// same sweep clears the centre and mass stores, with s_axis_tready low. the
// result sits in an output register; while the receiver stalls, new beats
// are still taken, and the next result waits until the register is free.
module weighted_kmeans_lloyd_pass_core #(
  parameter int unsigned CENTRES = 8,
  parameter int unsigned DIMS    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // centre_index, dim_index, value, point_weight, pad
  input  logic [1:0]  s_axis_tuser,  // command
  input  logic        s_axis_tlast,  // last_dim
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // nearest_centre, cost_value, pad
  output logic        m_axis_tuser   // result_kind
);
  import wkm_pkg::*;

  localparam int unsigned N  = CENTRES * DIMS;
  localparam int unsigned KW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned JW = (CENTRES > 1) ? $clog2(CENTRES) : 1;
  localparam int unsigned AW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam logic [COST_W-1:0] ALL_ONES = '1;
  localparam logic signed [VAL_W-1:0] MAX48 = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] MIN48 = {1'b1, {(VAL_W-1){1'b0}}};

  // input fields
  cmd_e                    in_cmd;
  logic [IDX_W-1:0]        in_ci, in_di;
  logic signed [VAL_W-1:0] in_val;
  logic [PW_W-1:0]         in_pw;
  logic                    acc_in;

  assign in_cmd = cmd_e'(s_axis_tuser);
  assign in_ci  = s_axis_tdata[5:0];
  assign in_di  = s_axis_tdata[11:6];
  assign in_val = s_axis_tdata[59:12];
  assign in_pw  = s_axis_tdata[75:60];
  assign acc_in = s_axis_tvalid && s_axis_tready;

  // memories
  logic signed [VAL_W-1:0] csum_mem [N];
  logic signed [VAL_W-1:0] msum_mem [N];
  logic [WGT_W-1:0]        cw_mem   [CENTRES];
  logic [WGT_W-1:0]        mw_mem   [CENTRES];
  logic signed [VAL_W-1:0] pb_mem   [DIMS];

  logic                    cs_we, ms_we, cw_we, mw_we, pb_we;
  logic [KW-1:0]           cs_wa, ms_wa, ms_ra;
  logic [JW-1:0]           cw_wa, mw_wa, mw_ra;
  logic [AW-1:0]           pb_wa, pb_ra;
  logic signed [VAL_W-1:0] cs_wd, ms_wd;
  logic [WGT_W-1:0]        cw_wd, mw_wd;
  logic signed [VAL_W-1:0] cs_rd_q, ms_rd_q, pb_rd_q;
  logic [WGT_W-1:0]        cw_rd_q, mw_rd_q;

  // control registers
  state_e            state_q, state_d;
  logic [KW:0]       sw_k_q, sw_k_d;
  logic              sw_wr_q, sw_wr_d;
  logic [KW-1:0]     sw_a_q, sw_a_d;
  logic              sw_clr_q, sw_clr_d;
  logic              sw_fin_q, sw_fin_d;
  logic [JW-1:0]     sj_q, sj_d;
  logic [AW-1:0]     sl_q, sl_d;
  logic [KW-1:0]     sk_q, sk_d;
  logic [KW-1:0]     mk_q, mk_d;
  logic [AW-1:0]     ml_q, ml_d;
  logic              iss_q, iss_d;
  tag_t              iss_tag_q, iss_tag_d;
  logic [PW_W-1:0]   pw_q, pw_d;
  logic [COST_W-1:0] pass_q, pass_d;
  res_kind_e         res_kind_q, res_kind_d;
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic [COST_W-1:0] res_cost_q, res_cost_d;
  logic              out_vld_q, out_vld_d;
  res_kind_e         out_kind_q, out_kind_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [COST_W-1:0] out_cost_q, out_cost_d;

  // distance pipeline
  logic                    pc_vld, cc_vld;
  logic signed [VAL_W-1:0] pc_quot, cc_quot;
  tag_t                    pc_tag, cc_tag;
  logic                    s1_vld_q, s1_big_q;
  logic [WGT_W-1:0]        s1_mag_q;
  tag_t                    s1_tag_q;
  logic                    s2_vld_q;
  logic [COST_W-1:0]       s2_sq_q;
  tag_t                    s2_tag_q;
  logic [COST_W-1:0]       acc_q, best_q;
  logic [IDX_W-1:0]        bestj_q;
  logic                    scan_done;

  logic [11:0]             load_lin, best_lin;
  logic [VAL_W:0]          diff;
  logic [VAL_W:0]          mag;
  logic [COST_W:0]         dist_sum;
  logic [COST_W-1:0]       dist_sat;
  logic [COST_W+PW_W-1:0]  prod;
  logic [COST_W:0]         pass_sum;
  logic [VAL_W:0]          mass_sum;
  logic [WGT_W:0]          mw_sum;

  assign load_lin = 12'(in_ci) * 12'(DIMS) + 12'(in_di);
  assign best_lin = 12'(bestj_q) * 12'(DIMS);

  always_ff @(posedge clk_i) begin
    if (cs_we) csum_mem[cs_wa] <= cs_wd;
    cs_rd_q <= csum_mem[sk_q];
  end

  always_ff @(posedge clk_i) begin
    if (ms_we) msum_mem[ms_wa] <= ms_wd;
    ms_rd_q <= msum_mem[ms_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cw_we) cw_mem[cw_wa] <= cw_wd;
    cw_rd_q <= cw_mem[sj_q];
  end

  always_ff @(posedge clk_i) begin
    if (mw_we) mw_mem[mw_wa] <= mw_wd;
    mw_rd_q <= mw_mem[mw_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pb_we) pb_mem[pb_wa] <= in_val;
    pb_rd_q <= pb_mem[pb_ra];
  end

  assign pass_sum = {1'b0, pass_q} + {1'b0, res_cost_q};
  assign prod     = best_q * pw_q;
  assign mass_sum = {ms_rd_q[VAL_W-1], ms_rd_q} + {pb_rd_q[VAL_W-1], pb_rd_q};
  assign mw_sum   = {1'b0, mw_rd_q} + (WGT_W+1)'(pw_q);

  always_comb begin
    state_d    = state_q;
    sw_k_d     = sw_k_q;
    sw_wr_d    = 1'b0;
    sw_a_d     = sw_k_q[KW-1:0];
    sw_clr_d   = sw_clr_q;
    sw_fin_d   = sw_fin_q;
    sj_d       = sj_q;
    sl_d       = sl_q;
    sk_d       = sk_q;
    mk_d       = mk_q;
    ml_d       = ml_q;
    iss_d      = 1'b0;
    iss_tag_d  = iss_tag_q;
    pw_d       = pw_q;
    pass_d     = pass_q;
    res_kind_d = res_kind_q;
    res_idx_d  = res_idx_q;
    res_cost_d = res_cost_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_kind_d = out_kind_q;
    out_idx_d  = out_idx_q;
    out_cost_d = out_cost_q;

    cs_we = 1'b0;
    cs_wa = load_lin[KW-1:0];
    cs_wd = in_val;
    ms_we = 1'b0;
    ms_wa = sw_k_q[KW-1:0];
    ms_wd = '0;
    ms_ra = sw_k_q[KW-1:0];
    cw_we = 1'b0;
    cw_wa = in_ci[JW-1:0];
    cw_wd = in_val[WGT_W-1:0];
    mw_we = 1'b0;
    mw_wa = sw_k_q[JW-1:0];
    mw_wd = '0;
    mw_ra = bestj_q[JW-1:0];
    pb_we = 1'b0;
    pb_wa = in_di[AW-1:0];
    pb_ra = ml_q;

    // delayed half of the sweep: centre takes the mass read last cycle
    if (sw_wr_q) begin
      cs_we = 1'b1;
      cs_wa = sw_a_q;
      cs_wd = sw_clr_q ? '0 : ms_rd_q;
      if ((KW+1)'(sw_a_q) < (KW+1)'(CENTRES)) begin
        cw_we = 1'b1;
        cw_wa = sw_a_q[JW-1:0];
        cw_wd = sw_clr_q ? '0 : mw_rd_q;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          case (in_cmd)
            CMD_LOAD_SUM: begin
              if ({1'b0, in_ci} < 7'(CENTRES) && {1'b0, in_di} < 7'(DIMS)) cs_we = 1'b1;
            end
            CMD_LOAD_WGT: begin
              if ({1'b0, in_ci} < 7'(CENTRES)) cw_we = 1'b1;
            end
            CMD_POINT: begin
              if ({1'b0, in_di} < 7'(DIMS)) pb_we = 1'b1;
              if (s_axis_tlast) begin
                pw_d    = in_pw;
                sj_d    = '0;
                sl_d    = '0;
                sk_d    = '0;
                state_d = ST_SCAN;
              end
            end
            CMD_FINISH: begin
              res_kind_d = RES_TOTAL;
              res_idx_d  = '0;
              res_cost_d = pass_q;
              pass_d     = '0;
              sw_k_d     = '0;
              sw_fin_d   = 1'b1;
              state_d    = ST_SWEEP;
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        if (sw_k_q < (KW+1)'(N)) begin
          ms_we   = 1'b1;
          sw_wr_d = 1'b1;
          if (sw_k_q < (KW+1)'(CENTRES)) mw_we = 1'b1;
          mw_ra  = sw_k_q[JW-1:0];
          sw_k_d = sw_k_q + 1'b1;
        end else begin
          sw_clr_d = 1'b0;
          sw_fin_d = 1'b0;
          state_d  = sw_fin_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_SCAN: begin
        pb_ra            = sl_q;
        iss_d            = 1'b1;
        iss_tag_d.last_l = (sl_q == AW'(DIMS - 1));
        iss_tag_d.ctr    = IDX_W'(sj_q);
        sk_d             = sk_q + 1'b1;
        if (sl_q == AW'(DIMS - 1)) begin
          sl_d = '0;
          sj_d = sj_q + 1'b1;
          if (sj_q == JW'(CENTRES - 1)) state_d = ST_DRAIN;
        end else begin
          sl_d = sl_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (scan_done) state_d = ST_COST;
      end
      ST_COST: begin
        res_kind_d = RES_POINT;
        res_idx_d  = bestj_q;
        res_cost_d = (|prod[COST_W+PW_W-1:COST_W]) ? ALL_ONES : prod[COST_W-1:0];
        state_d    = ST_CADD;
      end
      ST_CADD: begin
        pass_d = pass_sum[COST_W] ? ALL_ONES : pass_sum[COST_W-1:0];
        mk_d   = best_lin[KW-1:0];
        ml_d   = '0;
        state_d = (pw_q != '0) ? ST_MRD : ST_EMIT;
      end
      ST_MRD: begin
        ms_ra   = mk_q;
        state_d = ST_MWR;
      end
      ST_MWR: begin
        ms_we = 1'b1;
        ms_wa = mk_q;
        if (mass_sum[VAL_W] != mass_sum[VAL_W-1]) begin
          ms_wd = mass_sum[VAL_W] ? MIN48 : MAX48;
        end else begin
          ms_wd = mass_sum[VAL_W-1:0];
        end
        if (ml_q == AW'(DIMS - 1)) begin
          state_d = ST_MWGT;
        end else begin
          ml_d    = ml_q + 1'b1;
          mk_d    = mk_q + 1'b1;
          state_d = ST_MRD;
        end
      end
      ST_MWGT: begin
        mw_we   = 1'b1;
        mw_wa   = bestj_q[JW-1:0];
        mw_wd   = mw_sum[WGT_W] ? '1 : mw_sum[WGT_W-1:0];
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_kind_d = res_kind_q;
          out_idx_d  = res_idx_q;
          out_cost_d = res_cost_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      sw_k_q    <= '0;
      sw_wr_q   <= 1'b0;
      sw_clr_q  <= 1'b1;
      sw_fin_q  <= 1'b0;
      sj_q      <= '0;
      sl_q      <= '0;
      sk_q      <= '0;
      mk_q      <= '0;
      ml_q      <= '0;
      iss_q     <= 1'b0;
      pass_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sw_k_q    <= sw_k_d;
      sw_wr_q   <= sw_wr_d;
      sw_clr_q  <= sw_clr_d;
      sw_fin_q  <= sw_fin_d;
      sj_q      <= sj_d;
      sl_q      <= sl_d;
      sk_q      <= sk_d;
      mk_q      <= mk_d;
      ml_q      <= ml_d;
      iss_q     <= iss_d;
      pass_q    <= pass_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sw_a_q     <= sw_a_d;
    iss_tag_q  <= iss_tag_d;
    pw_q       <= pw_d;
    res_kind_q <= res_kind_d;
    res_idx_q  <= res_idx_d;
    res_cost_q <= res_cost_d;
    out_kind_q <= out_kind_d;
    out_idx_q  <= out_idx_d;
    out_cost_q <= out_cost_d;
  end

  wkm_div_chain u_point_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (iss_q),
    .dividend_i (pb_rd_q),
    .divisor_i  (WGT_W'(pw_q)),
    .tag_i      (iss_tag_q),
    .vld_o      (pc_vld),
    .quot_o     (pc_quot),
    .tag_o      (pc_tag)
  );

  wkm_div_chain u_centre_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (iss_q),
    .dividend_i (cs_rd_q),
    .divisor_i  (cw_rd_q),
    .tag_i      (iss_tag_q),
    .vld_o      (cc_vld),
    .quot_o     (cc_quot),
    .tag_o      (cc_tag)
  );

  assign diff = {pc_quot[VAL_W-1], pc_quot} - {cc_quot[VAL_W-1], cc_quot};
  assign mag  = diff[VAL_W] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      s1_vld_q <= cc_vld;
      s2_vld_q <= s1_vld_q;
      if (s2_vld_q) acc_q <= s2_tag_q.last_l ? '0 : dist_sat;
    end
  end

  assign dist_sum  = {1'b0, acc_q} + {1'b0, s2_sq_q};
  assign dist_sat  = dist_sum[COST_W] ? ALL_ONES : dist_sum[COST_W-1:0];
  assign scan_done = s2_vld_q && s2_tag_q.last_l && (s2_tag_q.ctr == IDX_W'(CENTRES - 1));

  always_ff @(posedge clk_i) begin
    s1_mag_q <= mag[WGT_W-1:0];
    s1_big_q <= |mag[VAL_W:WGT_W];
    s1_tag_q <= cc_tag;
    s2_sq_q  <= s1_big_q ? ALL_ONES : (COST_W'(s1_mag_q) * COST_W'(s1_mag_q));
    s2_tag_q <= s1_tag_q;
    // lowest index wins ties
    if (s2_vld_q && s2_tag_q.last_l && (s2_tag_q.ctr == '0 || dist_sat < best_q)) begin
      best_q  <= dist_sat;
      bestj_q <= s2_tag_q.ctr;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {2'b00, out_cost_q, out_idx_q};

`ifndef SYNTHESIS
  a_div_rows_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_vld == cc_vld && (!pc_vld || pc_tag == cc_tag))
    else $error("divider rows out of step");

  a_finish_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in && in_cmd == CMD_FINISH |=> !s_axis_tready)
    else $error("finish beat did not start the sweep");

  a_done_in_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> state_q == ST_DRAIN)
    else $error("scan finished outside drain");
`endif

endmodule

// ===== sim/weighted_kmeans_lloyd_pass_core_tb.sv =====
`timescale 1ns / 1ps
// testbench for weighted_kmeans_lloyd_pass_core: directed and random beats, with a
// predictor that tracks centres, masses and pass cost; depends on wkm_pkg and the core
module weighted_kmeans_lloyd_pass_core_tb;
  import wkm_pkg::*;

  localparam int CENTRES = 8;
  localparam int DIMS    = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    res_kind_e   kind;
    bit [5:0]    centre;
    bit [63:0]   cost;
  } lloyd_result_t;

  class lloyd_tracker;
    longint          centre_sum [CENTRES][DIMS];
    longint unsigned centre_wgt [CENTRES];
    longint          mass_sum [CENTRES][DIMS];
    longint unsigned mass_wgt [CENTRES];
    longint          point_buf [DIMS];
    longint unsigned pass_total;
    lloyd_result_t   pending_results[$];
    int              errors;

    function void clear_masses();
      foreach (mass_sum[j, l]) mass_sum[j][l] = 0;
      foreach (mass_wgt[j]) mass_wgt[j] = 0;
    endfunction

    function void reset_state();
      foreach (centre_sum[j, l]) centre_sum[j][l] = 0;
      foreach (centre_wgt[j]) centre_wgt[j] = 0;
      foreach (point_buf[l]) point_buf[l] = 0;
      clear_masses();
      pass_total = 0;
      errors = 0;
    endfunction

    function longint unsigned sat_add(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s < a) ? '1 : s;
    endfunction

    // truncating division gives the q.16 coordinate; zero weight keeps the raw sum
    function longint coord(longint s, longint unsigned w);
      if (w == 0) return s;
      return s / longint'(w);
    endfunction

    function longint unsigned sq_diff(longint a, longint b);
      longint d;
      longint unsigned m;
      d = a - b;
      m = (d < 0) ? longint'(-d) : d;
      if (m >= 64'h1_0000_0000) return '1;
      return m * m;
    endfunction

    function void note_beat(cmd_e cmd, bit [5:0] ci, bit [5:0] di, bit [47:0] v,
                            bit [15:0] pw, bit last);
      longint          val;
      longint unsigned cand_dist, best_dist, cost, mw;
      longint          s;
      bit [127:0]      prod;
      int              best;
      lloyd_result_t   r;
      val = longint'($signed(v));
      case (cmd)
        CMD_LOAD_SUM: begin
          if (ci < CENTRES && di < DIMS) centre_sum[ci][di] = val;
        end
        CMD_LOAD_WGT: begin
          if (ci < CENTRES) centre_wgt[ci] = v[31:0];
        end
        CMD_FINISH: begin
          centre_sum = mass_sum;
          centre_wgt = mass_wgt;
          r.kind = RES_TOTAL;
          r.centre = 0;
          r.cost = pass_total;
          pending_results.push_back(r);
          pass_total = 0;
          clear_masses();
        end
        default: begin
          if (di < DIMS) point_buf[di] = val;
          if (last) begin
            best = 0;
            best_dist = 0;
            for (int j = 0; j < CENTRES; j++) begin
              cand_dist = 0;
              for (int l = 0; l < DIMS; l++)
                cand_dist = sat_add(cand_dist, sq_diff(coord(point_buf[l], pw),
                                    coord(centre_sum[j][l], centre_wgt[j])));
              if (j == 0 || cand_dist < best_dist) begin
                best_dist = cand_dist;
                best = j;
              end
            end
            prod = best_dist * pw;
            cost = (prod[127:64] != 0) ? '1 : prod[63:0];
            pass_total = sat_add(pass_total, cost);
            if (pw != 0) begin
              for (int l = 0; l < DIMS; l++) begin
                s = mass_sum[best][l] + point_buf[l];
                if (s > 64'sd140737488355327) s = 64'sd140737488355327;
                if (s < -64'sd140737488355328) s = -64'sd140737488355328;
                mass_sum[best][l] = s;
              end
              mw = mass_wgt[best] + pw;
              mass_wgt[best] = (mw > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : mw;
            end
            r.kind = RES_POINT;
            r.centre = best[5:0];
            r.cost = cost;
            pending_results.push_back(r);
          end
        end
      endcase
    endfunction

    function void check_result(res_kind_e kind, bit [5:0] centre, bit [63:0] cost);
      lloyd_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: kind %0d centre %0d cost %0h", kind, centre, cost);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (kind != e.kind) begin
        $error("result_kind: expected %0d actual %0d", e.kind, kind);
        errors++;
      end
      if (centre != e.centre) begin
        $error("nearest_centre: expected %0d actual %0d", e.centre, centre);
        errors++;
      end
      if (cost != e.cost) begin
        $error("cost_value: expected %0h actual %0h", e.cost, cost);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // centre_index, dim_index, value, point_weight, pad
  logic [1:0]  s_axis_tuser = '0;  // command
  logic        s_axis_tlast = 1'b0;  // last_dim
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;  // nearest_centre, cost_value, pad
  logic        m_axis_tuser;  // result_kind

  lloyd_tracker tracker = new();
  bit           no_idle;
  int           beats_sent;
  int           quiet_cycles;

  weighted_kmeans_lloyd_pass_core #(.CENTRES(CENTRES), .DIMS(DIMS)) i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // caller sits at a rising edge; returns at the edge where the beat is taken
  task automatic send_beat(cmd_e cmd, bit [5:0] ci, bit [5:0] di, bit [47:0] v,
                           bit [15:0] pw, bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {4'b0, pw, v, di, ci};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    tracker.note_beat(cmd, ci, di, v, pw, last);
    beats_sent++;
    if (beats_sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
  endtask

  function automatic bit [47:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 48'({$urandom, $urandom});
      1:       return 48'h7FFF_FFFF_FFFF;
      2:       return 48'h8000_0000_0000;
      default: return 48'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic bit [15:0] rand_weight();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic send_point();
    bit [15:0] pw;
    bit        broken;
    int        n;
    pw = rand_weight();
    broken = ($urandom_range(0, 7) == 0);
    n = broken ? $urandom_range(1, DIMS) : DIMS;
    for (int l = 0; l < n; l++)
      send_beat(CMD_POINT, 6'($urandom), broken ? 6'($urandom_range(0, 63)) : 6'(l),
                rand_value(), (l == n - 1) ? pw : 16'($urandom), l == n - 1);
  endtask

  // receiver: random stall before each result beat
  initial begin
    int  stall;
    bit [71:0] d;
    bit  k;
    wait (rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      d = m_axis_tdata;
      k = m_axis_tuser;
      @(posedge clk_i);
      tracker.check_result(res_kind_e'(k), d[5:0], d[69:6]);
    end
  end

  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int pick;
    tracker.reset_state();
    quiet_cycles = 0;
    beats_sent = 0;
    no_idle = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, out-of-range loads, wrapped weight, stale buffer, zero weight
    send_beat(CMD_LOAD_SUM, 0, 0, 48'h7FFF_FFFF_FFFF, 0, 0);
    send_beat(CMD_LOAD_SUM, 63, 63, 48'h1234, 16'hFFFF, 1);
    send_beat(CMD_LOAD_SUM, 7, 7, 48'h8000_0000_0000, 0, 0);
    send_beat(CMD_LOAD_SUM, 3, 9, 48'h55, 0, 0);
    send_beat(CMD_LOAD_WGT, 7, 0, 48'hFFFF_FFFF_FFFF, 0, 0);
    send_beat(CMD_LOAD_WGT, 9, 0, 48'h5, 0, 0);
    send_beat(CMD_LOAD_WGT, 0, 0, 48'h2, 0, 0);
    for (int l = 0; l < DIMS; l++)
      send_beat(CMD_POINT, 0, 6'(l), (l == 1) ? 48'h8000_0000_0000 : 48'(l << 16),
                16'hFFFF, l == DIMS - 1);
    send_beat(CMD_POINT, 0, 63, 48'h7FFF_FFFF_FFFF, 16'd0, 1);
    send_beat(CMD_POINT, 0, 3, 48'h3_0000, 16'd1, 1);
    send_beat(CMD_FINISH, 0, 0, 0, 0, 0);
    send_beat(CMD_FINISH, 0, 0, 0, 0, 0);
    send_beat(CMD_POINT, 0, 0, 48'h1_0000, 16'd5, 1);

    while (beats_sent < 450) begin
      if (beats_sent > 200 && beats_sent < 215) begin
        // let the pipeline drain completely before sending more
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (tracker.pending_results.size() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(0, 19);
      if (pick < 2)
        send_beat(CMD_LOAD_SUM, ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)),
                  ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)),
                  rand_value(), 16'($urandom), 1'($urandom));
      else if (pick < 3)
        send_beat(CMD_LOAD_WGT, ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)),
                  6'($urandom), ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom})
                  : 48'($urandom_range(0, 9)), 16'($urandom), 1'($urandom));
      else if (pick < 4)
        send_beat(CMD_FINISH, 6'($urandom), 6'($urandom), rand_value(), 16'($urandom),
                  1'($urandom));
      else
        send_point();
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
